// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the top-level RTL. Every check is sampled on the rising
// clock edge and switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RPQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define RPQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/core/rpq_pkg.sv =====
`default_nettype none

package rpq_pkg;

   // working width for sums of a 32 bit coordinate and a 33 bit extent
   typedef logic signed [35:0] wide_type;

   typedef logic [2:0] region_type;

   localparam region_type RGN_BELOW_RIGHT = 3'd0;
   localparam region_type RGN_BELOW       = 3'd1;
   localparam region_type RGN_BELOW_LEFT  = 3'd2;
   localparam region_type RGN_LEFT        = 3'd3;
   localparam region_type RGN_ABOVE_LEFT  = 3'd4;
   localparam region_type RGN_ABOVE       = 3'd5;
   localparam region_type RGN_ABOVE_RIGHT = 3'd6;
   localparam region_type RGN_RIGHT       = 3'd7;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_CENTER_X   = 3'd0;
   localparam csr_index_type CSR_CENTER_Y   = 3'd1;
   localparam csr_index_type CSR_BOX_WIDTH  = 3'd2;
   localparam csr_index_type CSR_BOX_HEIGHT = 3'd3;
   localparam csr_index_type CSR_OUT_SCALE  = 3'd4;

   localparam logic [9:0] OUT_SCALE_RESET = 10'd282;

   localparam wide_type SAT_MAX = wide_type'(32'sh7FFF_FFFF);
   localparam wide_type SAT_MIN = wide_type'(32'sh8000_0000);

   // Geometry derived from the registers, recomputed every cycle.
   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [29:0]        w2;
      logic [29:0]        h2;
      logic [31:0]        sw;
      logic [31:0]        sh;
      logic signed [31:0] xl;
      logic signed [31:0] xr;
      logic signed [31:0] yl;
      logic signed [31:0] yh;
      logic signed [31:0] pxl;
      logic signed [31:0] pxr;
      logic signed [31:0] pyl;
      logic signed [31:0] pyh;
   } geom_type;

   typedef struct packed {
      region_type         region;
      logic               in_box;
      logic signed [31:0] lx;
      logic signed [31:0] ly;
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] pux;
      logic signed [31:0] puy;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
   } result_type;

   function automatic logic signed [31:0] sat32(input wide_type v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rpq_cfg.sv =====
`default_nettype none

module rpq_cfg (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire rpq_pkg::csr_index_type csr_index,
   input  wire logic [31:0]            csr_data,
   output rpq_pkg::geom_type           geom
);
   import rpq_pkg::*;

   logic signed [31:0] center_x_ff, center_x_in;
   logic signed [31:0] center_y_ff, center_y_in;
   logic [30:0]        box_width_ff, box_width_in;
   logic [30:0]        box_height_ff, box_height_in;
   logic [9:0]         out_scale_ff, out_scale_in;
   geom_type           geom_ff, geom_in;

   logic               wr_en;
   logic [29:0]        w2;
   logic [29:0]        h2;
   logic [39:0]        sw_rnd;
   logic [39:0]        sh_rnd;
   wide_type           cxw;
   wide_type           cyw;
   wide_type           w2w;
   wide_type           h2w;
   wide_type           sww;
   wide_type           shw;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   always_comb begin
      center_x_in   = center_x_ff;
      center_y_in   = center_y_ff;
      box_width_in  = box_width_ff;
      box_height_in = box_height_ff;
      out_scale_in  = out_scale_ff;
      if (wr_en) begin
         case (csr_index)
            CSR_CENTER_X:   center_x_in   = csr_data;
            CSR_CENTER_Y:   center_y_in   = csr_data;
            CSR_BOX_WIDTH:  box_width_in  = csr_data[30:0];
            CSR_BOX_HEIGHT: box_height_in = csr_data[30:0];
            CSR_OUT_SCALE:  out_scale_in  = csr_data[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         box_width_ff  <= '0;
         box_height_ff <= '0;
         out_scale_ff  <= OUT_SCALE_RESET;
      end else begin
         center_x_ff   <= center_x_in;
         center_y_ff   <= center_y_in;
         box_width_ff  <= box_width_in;
         box_height_ff <= box_height_in;
         out_scale_ff  <= out_scale_in;
      end
   end

   // half extents floor, scaled extents round to nearest
   assign w2     = box_width_ff[30:1];
   assign h2     = box_height_ff[30:1];
   assign sw_rnd = ({10'd0, w2} * {30'd0, out_scale_ff}) + 40'd128;
   assign sh_rnd = ({10'd0, h2} * {30'd0, out_scale_ff}) + 40'd128;

   assign cxw = wide_type'(center_x_ff);
   assign cyw = wide_type'(center_y_ff);
   assign w2w = $signed({6'd0, w2});
   assign h2w = $signed({6'd0, h2});
   assign sww = $signed({4'd0, sw_rnd[39:8]});
   assign shw = $signed({4'd0, sh_rnd[39:8]});

   always_comb begin
      geom_in.cx  = center_x_ff;
      geom_in.cy  = center_y_ff;
      geom_in.w2  = w2;
      geom_in.h2  = h2;
      geom_in.sw  = sw_rnd[39:8];
      geom_in.sh  = sh_rnd[39:8];
      geom_in.xl  = sat32(cxw - w2w);
      geom_in.xr  = sat32(cxw + w2w);
      geom_in.yl  = sat32(cyw - h2w);
      geom_in.yh  = sat32(cyw + h2w);
      geom_in.pxl = sat32(cxw - sww);
      geom_in.pxr = sat32(cxw + sww);
      geom_in.pyl = sat32(cyw - shw);
      geom_in.pyh = sat32(cyw + shw);
   end

   // reset value matches the register reset: every derived term is zero
   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff <= '0;
      end else begin
         geom_ff <= geom_in;
      end
   end

   assign geom = geom_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rpq_eval.sv =====
`default_nettype none

module rpq_eval (
   input  wire rpq_pkg::geom_type   geom,
   input  wire logic signed [31:0]  point_x,
   input  wire logic signed [31:0]  point_y,
   output rpq_pkg::result_type      res
);
   import rpq_pkg::*;

   wide_type   dx, dy;
   wide_type   w2w, h2w;
   wide_type   dxm, dxp, dym, dyp;
   wide_type   adx, ady;
   wide_type   swd, shd;
   wide_type   wd, hd;
   wide_type   fx, fy;
   logic       push_side_x;
   logic       face_x;
   logic       in_box;
   region_type region;

   assign dx  = wide_type'(point_x) - wide_type'(geom.cx);
   assign dy  = wide_type'(point_y) - wide_type'(geom.cy);
   assign w2w = $signed({6'd0, geom.w2});
   assign h2w = $signed({6'd0, geom.h2});
   assign dxm = dx - w2w;
   assign dxp = dx + w2w;
   assign dym = dy - h2w;
   assign dyp = dy + h2w;
   assign adx = dx[35] ? -dx : dx;
   assign ady = dy[35] ? -dy : dy;

   assign swd         = $signed({4'd0, geom.sw}) - adx;
   assign shd         = $signed({4'd0, geom.sh}) - ady;
   assign push_side_x = swd < shd;
   assign wd          = w2w - adx;
   assign hd          = h2w - ady;
   assign face_x      = wd < hd;

   assign in_box = (dxp > 0) && (dxm < 0) && (dyp > 0) && (dym < 0);

   always_comb begin
      if (dyp <= 0) begin
         if (dxm >= 0) begin
            region = RGN_BELOW_RIGHT;
         end else if (dxp > 0) begin
            region = RGN_BELOW;
         end else begin
            region = RGN_BELOW_LEFT;
         end
      end else if (dym < 0) begin
         region = dx[35] ? RGN_LEFT : RGN_RIGHT;
      end else begin
         if (dxp <= 0) begin
            region = RGN_ABOVE_LEFT;
         end else if (dxm < 0) begin
            region = RGN_ABOVE;
         end else begin
            region = RGN_ABOVE_RIGHT;
         end
      end
   end

   always_comb begin
      res.region = region;
      res.in_box = in_box;
      case (region)
         RGN_BELOW_RIGHT: begin
            res.lx = geom.xr; res.ly = geom.yh; res.rx = geom.xl; res.ry = geom.yl;
         end
         RGN_BELOW: begin
            res.lx = geom.xr; res.ly = geom.yl; res.rx = geom.xl; res.ry = geom.yl;
         end
         RGN_BELOW_LEFT: begin
            res.lx = geom.xr; res.ly = geom.yl; res.rx = geom.xl; res.ry = geom.yh;
         end
         RGN_LEFT: begin
            res.lx = geom.xl; res.ly = geom.yl; res.rx = geom.xl; res.ry = geom.yh;
         end
         RGN_ABOVE_LEFT: begin
            res.lx = geom.xl; res.ly = geom.yl; res.rx = geom.xr; res.ry = geom.yh;
         end
         RGN_ABOVE: begin
            res.lx = geom.xl; res.ly = geom.yh; res.rx = geom.xr; res.ry = geom.yh;
         end
         RGN_ABOVE_RIGHT: begin
            res.lx = geom.xl; res.ly = geom.yh; res.rx = geom.xr; res.ry = geom.yl;
         end
         default: begin
            res.lx = geom.xr; res.ly = geom.yh; res.rx = geom.xr; res.ry = geom.yl;
         end
      endcase

      // push out along the side with less scaled clearance
      if (push_side_x) begin
         res.pux = dx[35] ? geom.pxl : geom.pxr;
         res.puy = point_y;
      end else begin
         res.pux = point_x;
         res.puy = dy[35] ? geom.pyl : geom.pyh;
      end

      if (in_box) begin
         if (face_x) begin
            fx = dx[35] ? dxp : dxm;
            fy = '0;
         end else begin
            fx = '0;
            fy = dy[35] ? dyp : dym;
         end
      end else begin
         case (region)
            RGN_BELOW_RIGHT: begin fx = dxm; fy = dyp; end
            RGN_BELOW:       begin fx = '0;  fy = dyp; end
            RGN_BELOW_LEFT:  begin fx = dxp; fy = dyp; end
            RGN_LEFT:        begin fx = dxp; fy = '0;  end
            RGN_ABOVE_LEFT:  begin fx = dxp; fy = dym; end
            RGN_ABOVE:       begin fx = '0;  fy = dym; end
            RGN_ABOVE_RIGHT: begin fx = dxm; fy = dym; end
            default:         begin fx = dxm; fy = '0;  end
         endcase
      end
      res.fx = sat32(fx);
      res.fy = sat32(fy);
   end

endmodule

`default_nettype wire

// ===== rtl/core/rectangle_point_region_query.sv =====
// Rectangle point region query. Each request beat carries one query point
// (signed Q16.16); the response beat gives the region around the box (0..7),
// the strict-inside flag, the two silhouette corners seen from the point,
// the push-out point on the nearer scaled side and the vector from the
// nearest surface point, every coordinate saturated to signed 32 bits.
// Throughput is one point per clock while rsp_stall is low. An accepted
// point lands in an input register, and one pass of compare/add logic
// fills the response register from it when the pipe advances. The
// response register and the input register together hold two points, so a
// new request is taken while a finished response waits under rsp_stall.
// Geometry derived from the csr registers (half extents, scaled extents,
// corners) is held in a register of its own behind them: leave at least one
// clock between the last csr write and the next request beat. csr_ready is
// always high; csr_index 5 to 7 are ignored.
`default_nettype none

module rectangle_point_region_query (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic signed [31:0]     req_point_x,
   input  wire logic signed [31:0]     req_point_y,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [2:0]                  rsp_region,
   output logic                        rsp_inside_res,
   output logic signed [31:0]          rsp_left_corner_x,
   output logic signed [31:0]          rsp_left_corner_y,
   output logic signed [31:0]          rsp_right_corner_x,
   output logic signed [31:0]          rsp_right_corner_y,
   output logic signed [31:0]          rsp_push_x,
   output logic signed [31:0]          rsp_push_y,
   output logic signed [31:0]          rsp_diff_x,
   output logic signed [31:0]          rsp_diff_y,
   // csr write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire rpq_pkg::csr_index_type csr_index,
   input  wire logic [31:0]            csr_data
);
   import rpq_pkg::*;

`include "assert_macros.svh"

   geom_type           geom;
   result_type         eval_res;

   logic               s1_valid_ff, s1_valid_in;
   logic signed [31:0] s1_px_ff;
   logic signed [31:0] s1_py_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         res_ff;

   logic               adv;
   logic               req_take;

   rpq_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom)
   );

   rpq_eval u_eval (
      .geom    (geom),
      .point_x (s1_px_ff),
      .point_y (s1_py_ff),
      .res     (eval_res)
   );

   // Advance the pipe whenever the response register is empty or draining.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   // Stall the request side only when both registers hold a point.
   assign req_stall = s1_valid_ff && !adv;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !adv);
   assign rsp_valid_in = adv ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the point on accept; hold it while the pipe is blocked.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_px_ff <= req_point_x;
         s1_py_ff <= req_point_y;
      end
   end

   // Load the response when the input stage moves forward.
   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         res_ff <= eval_res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_region         = res_ff.region;
   assign rsp_inside_res     = res_ff.in_box;
   assign rsp_left_corner_x  = res_ff.lx;
   assign rsp_left_corner_y  = res_ff.ly;
   assign rsp_right_corner_x = res_ff.rx;
   assign rsp_right_corner_y = res_ff.ry;
   assign rsp_push_x         = res_ff.pux;
   assign rsp_push_y         = res_ff.puy;
   assign rsp_diff_x         = res_ff.fx;
   assign rsp_diff_y         = res_ff.fy;

   // An inside point sits in the middle band, so it is left or right.
   `RPQ_ASSERT_IMP(a_inside_band, clock, reset, rsp_valid_ff && res_ff.in_box, res_ff.region == RGN_LEFT || res_ff.region == RGN_RIGHT)
   // An inside point is measured from one face only.
   `RPQ_ASSERT_IMP(a_inside_one_face, clock, reset, rsp_valid_ff && res_ff.in_box, res_ff.fx == '0 || res_ff.fy == '0)
   // Straight above or below the box there is no x offset.
   `RPQ_ASSERT_IMP(a_face_vector, clock, reset, rsp_valid_ff && !res_ff.in_box && (res_ff.region == RGN_BELOW || res_ff.region == RGN_ABOVE), res_ff.fx == '0)
   // A blocked input stage keeps its point.
   `RPQ_ASSERT_NXT(a_s1_hold, clock, reset, s1_valid_ff && !adv, s1_valid_ff && $stable(s1_px_ff) && $stable(s1_py_ff))

endmodule

`default_nettype wire

// ===== sim/region_query_checker.sv =====
`default_nettype none

module region_query_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic signed [31:0]     req_point_x,
   input  wire logic signed [31:0]     req_point_y,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic [2:0]             rsp_region,
   input  wire logic                   rsp_inside_res,
   input  wire logic signed [31:0]     rsp_left_corner_x,
   input  wire logic signed [31:0]     rsp_left_corner_y,
   input  wire logic signed [31:0]     rsp_right_corner_x,
   input  wire logic signed [31:0]     rsp_right_corner_y,
   input  wire logic signed [31:0]     rsp_push_x,
   input  wire logic signed [31:0]     rsp_push_y,
   input  wire logic signed [31:0]     rsp_diff_x,
   input  wire logic signed [31:0]     rsp_diff_y,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire rpq_pkg::csr_index_type csr_index,
   input  wire logic [31:0]            csr_data,
   output int                          fail_count,
   output int                          open_answers,
   output int                          checked_count,
   output int                          inside_hits
);
   timeunit 1ns;
   timeprecision 1ps;

   import rpq_pkg::*;

   typedef struct packed {
      logic signed [31:0] qx;
      logic signed [31:0] qy;
      region_type         rgn;
      logic               in_box;
      logic signed [31:0] lcx;
      logic signed [31:0] lcy;
      logic signed [31:0] rcx;
      logic signed [31:0] rcy;
      logic signed [31:0] pshx;
      logic signed [31:0] pshy;
      logic signed [31:0] dfx;
      logic signed [31:0] dfy;
   } box_answer_type;

   logic signed [31:0] box_cx;
   logic signed [31:0] box_cy;
   logic [30:0]        box_w;
   logic [30:0]        box_h;
   logic [9:0]         box_scale;

   box_answer_type pending_answers [$];

   initial begin
      fail_count    = 0;
      open_answers  = 0;
      checked_count = 0;
      inside_hits   = 0;
   end

   function automatic logic signed [31:0] clamp_s32(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // expected response for one query point against the current box
   function automatic box_answer_type classify_point(input logic signed [31:0] qx,
                                                     input logic signed [31:0] qy);
      longint px, py, cx, cy, w2, h2, dx, dy, adx, ady;
      longint xl, xr, yl, yh, lx, ly, rx, ry, sw, sh, pux, puy, fx, fy;
      box_answer_type a;
      px = qx;
      py = qy;
      cx = box_cx;
      cy = box_cy;
      w2 = longint'(box_w) >>> 1;
      h2 = longint'(box_h) >>> 1;
      dx = px - cx;
      dy = py - cy;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      xl = cx - w2;
      xr = cx + w2;
      yl = cy - h2;
      yh = cy + h2;
      a.qx = qx;
      a.qy = qy;

      if (dy <= -h2) begin
         a.rgn = (dx >= w2) ? RGN_BELOW_RIGHT : (dx > -w2) ? RGN_BELOW : RGN_BELOW_LEFT;
      end else if (dy < h2) begin
         a.rgn = (dx >= 0) ? RGN_RIGHT : RGN_LEFT;
      end else begin
         a.rgn = (dx <= -w2) ? RGN_ABOVE_LEFT : (dx < w2) ? RGN_ABOVE : RGN_ABOVE_RIGHT;
      end
      a.in_box = (dx > -w2) && (dx < w2) && (dy > -h2) && (dy < h2);

      case (a.rgn)
         RGN_BELOW_RIGHT: begin lx = xr; ly = yh; rx = xl; ry = yl; end
         RGN_BELOW:       begin lx = xr; ly = yl; rx = xl; ry = yl; end
         RGN_BELOW_LEFT:  begin lx = xr; ly = yl; rx = xl; ry = yh; end
         RGN_LEFT:        begin lx = xl; ly = yl; rx = xl; ry = yh; end
         RGN_ABOVE_LEFT:  begin lx = xl; ly = yl; rx = xr; ry = yh; end
         RGN_ABOVE:       begin lx = xl; ly = yh; rx = xr; ry = yh; end
         RGN_ABOVE_RIGHT: begin lx = xl; ly = yh; rx = xr; ry = yl; end
         default:         begin lx = xr; ly = yh; rx = xr; ry = yl; end
      endcase

      // scaled half extents, Q2.8 scale rounded to nearest
      sw = (w2 * longint'(box_scale) + 128) >>> 8;
      sh = (h2 * longint'(box_scale) + 128) >>> 8;
      if (sw - adx < sh - ady) begin
         pux = (dx < 0) ? cx - sw : cx + sw;
         puy = py;
      end else begin
         pux = px;
         puy = (dy < 0) ? cy - sh : cy + sh;
      end

      if (a.in_box) begin
         // nearer face; a tie goes to the y face
         if (w2 - adx < h2 - ady) begin
            fx = (dx >= 0) ? dx - w2 : dx + w2;
            fy = 0;
         end else begin
            fx = 0;
            fy = (dy >= 0) ? dy - h2 : dy + h2;
         end
      end else begin
         case (a.rgn)
            RGN_BELOW_RIGHT: begin fx = dx - w2; fy = dy + h2; end
            RGN_BELOW:       begin fx = 0;       fy = dy + h2; end
            RGN_BELOW_LEFT:  begin fx = dx + w2; fy = dy + h2; end
            RGN_LEFT:        begin fx = dx + w2; fy = 0;       end
            RGN_ABOVE_LEFT:  begin fx = dx + w2; fy = dy - h2; end
            RGN_ABOVE:       begin fx = 0;       fy = dy - h2; end
            RGN_ABOVE_RIGHT: begin fx = dx - w2; fy = dy - h2; end
            default:         begin fx = dx - w2; fy = 0;       end
         endcase
      end

      a.lcx  = clamp_s32(lx);
      a.lcy  = clamp_s32(ly);
      a.rcx  = clamp_s32(rx);
      a.rcy  = clamp_s32(ry);
      a.pshx = clamp_s32(pux);
      a.pshy = clamp_s32(puy);
      a.dfx  = clamp_s32(fx);
      a.dfy  = clamp_s32(fy);
      return a;
   endfunction

   task automatic check_field(input string what, input longint want, input longint got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= 40) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      box_answer_type want;
      int fails_before;
      if (reset) begin
         box_cx    = '0;
         box_cy    = '0;
         box_w     = '0;
         box_h     = '0;
         box_scale = OUT_SCALE_RESET;
         pending_answers.delete();
         open_answers <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CENTER_X:   box_cx    = csr_data;
               CSR_CENTER_Y:   box_cy    = csr_data;
               CSR_BOX_WIDTH:  box_w     = csr_data[30:0];
               CSR_BOX_HEIGHT: box_h     = csr_data[30:0];
               CSR_OUT_SCALE:  box_scale = csr_data[9:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            pending_answers.push_back(classify_point(req_point_x, req_point_y));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               fail_count++;
               if (fail_count <= 40) begin
                  $display("%0t: response beat with no point outstanding", $time);
               end
            end else begin
               want = pending_answers.pop_front();
               fails_before = fail_count;
               checked_count++;
               if (want.in_box) begin
                  inside_hits++;
               end
               check_field("region",         want.rgn,    rsp_region);
               check_field("inside_res",     want.in_box, rsp_inside_res);
               check_field("left_corner_x",  want.lcx,    rsp_left_corner_x);
               check_field("left_corner_y",  want.lcy,    rsp_left_corner_y);
               check_field("right_corner_x", want.rcx,    rsp_right_corner_x);
               check_field("right_corner_y", want.rcy,    rsp_right_corner_y);
               check_field("push_x",         want.pshx,   rsp_push_x);
               check_field("push_y",         want.pshy,   rsp_push_y);
               check_field("diff_x",         want.dfx,    rsp_diff_x);
               check_field("diff_y",         want.dfy,    rsp_diff_y);
               if (fail_count != fails_before && fails_before < 40) begin
                  $display("   point (%0d, %0d)", want.qx, want.qy);
               end
            end
         end
         open_answers <= pending_answers.size();
      end
   end

endmodule

`default_nettype wire

// ===== sim/rectangle_point_region_query_tb.sv =====
`default_nettype none

module rectangle_point_region_query_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rpq_pkg::*;

   localparam int UNIT = 1 << 16;   // 1.0 in Q16.16

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   wire                req_stall;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;

   wire                rsp_valid;
   logic               rsp_stall = 1'b0;
   wire [2:0]          rsp_region;
   wire                rsp_inside_res;
   wire signed [31:0]  rsp_left_corner_x;
   wire signed [31:0]  rsp_left_corner_y;
   wire signed [31:0]  rsp_right_corner_x;
   wire signed [31:0]  rsp_right_corner_y;
   wire signed [31:0]  rsp_push_x;
   wire signed [31:0]  rsp_push_y;
   wire signed [31:0]  rsp_diff_x;
   wire signed [31:0]  rsp_diff_y;

   logic               csr_valid = 1'b0;
   wire                csr_ready;
   csr_index_type      csr_index = CSR_CENTER_X;
   logic [31:0]        csr_data = '0;

   int fail_count;
   int open_answers;
   int checked_count;
   int inside_hits;

   // chance in percent, per beat or per cycle, that an idle burst starts
   int idle_pct = 0;
   int settings_used = 1;

   // copy of the programmed box, used only to aim points near its edges
   longint set_cx = 0;
   longint set_cy = 0;
   longint half_w = 0;
   longint half_h = 0;

   always #5 clock = ~clock;

   rectangle_point_region_query dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_region         (rsp_region),
      .rsp_inside_res     (rsp_inside_res),
      .rsp_left_corner_x  (rsp_left_corner_x),
      .rsp_left_corner_y  (rsp_left_corner_y),
      .rsp_right_corner_x (rsp_right_corner_x),
      .rsp_right_corner_y (rsp_right_corner_y),
      .rsp_push_x         (rsp_push_x),
      .rsp_push_y         (rsp_push_y),
      .rsp_diff_x         (rsp_diff_x),
      .rsp_diff_y         (rsp_diff_y),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   region_query_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_region         (rsp_region),
      .rsp_inside_res     (rsp_inside_res),
      .rsp_left_corner_x  (rsp_left_corner_x),
      .rsp_left_corner_y  (rsp_left_corner_y),
      .rsp_right_corner_x (rsp_right_corner_x),
      .rsp_right_corner_y (rsp_right_corner_y),
      .rsp_push_x         (rsp_push_x),
      .rsp_push_y         (rsp_push_y),
      .rsp_diff_x         (rsp_diff_x),
      .rsp_diff_y         (rsp_diff_y),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .open_answers       (open_answers),
      .checked_count      (checked_count),
      .inside_hits        (inside_hits)
   );

   // Offer one point and hold it until the block takes the beat. Valid stays
   // high into the next call unless an idle burst is drawn, so back-to-back
   // beats never lower and raise valid in the same step.
   task automatic send_point(input logic [31:0] x, input logic [31:0] y);
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every point has its response back.
   task automatic drain_points();
      req_valid <= 1'b0;
      do @(posedge clock); while (open_answers != 0);
   endtask

   // Raise a write beat and hold it until accepted; the caller drops valid.
   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Program a whole box while the block is idle. A junk write to one of the
   // unused indexes goes first; the block must ignore it.
   task automatic program_box(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] w, input logic [31:0] h,
                              input logic [31:0] scale);
      write_reg(csr_index_type'(CSR_OUT_SCALE + 3'($urandom_range(1, 3))), $urandom);
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      write_reg(CSR_BOX_WIDTH, w);
      write_reg(CSR_BOX_HEIGHT, h);
      write_reg(CSR_OUT_SCALE, scale);
      csr_valid <= 1'b0;
      set_cx = longint'(signed'(cx));
      set_cy = longint'(signed'(cy));
      half_w = longint'(w[30:0]) >>> 1;
      half_h = longint'(h[30:0]) >>> 1;
      settings_used++;
      // derived geometry is registered behind the csr registers; give it room
      repeat (2) @(posedge clock);
   endtask

   // Centre coordinate: origin, a moderate Q16.16 value, anything at all, or a
   // value near either limit (the last one drives corners and push-out points into saturation).
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 3))
         0:       return 32'd0;
         1:       return (32'($urandom_range(0, 2000)) - 32'd1000) << 16;
         2:       return $urandom;
         default: return $urandom_range(0, 1) ? 32'h7FF0_0000 + $urandom_range(0, 65535)
                                             : 32'h8010_0000 - $urandom_range(0, 65535);
      endcase
   endfunction

   // Full extent: zero, a few raw LSBs (odd values, ties are common), a
   // sensible size, or raw random with the ignored top bit set at times.
   function automatic logic [31:0] pick_extent();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return $urandom_range(1, 63);
         2:       return 32'($urandom_range(1, 400)) << 16;
         3:       return $urandom;
         default: return 32'($urandom_range(1, 4000)) << 12;
      endcase
   endfunction

   // One coordinate aimed at the box: mostly within one and a half half
   // extents of the centre, some exactly on or one off an edge, some wild.
   function automatic logic [31:0] near_coord(input longint centre, input longint half);
      longint span;
      span = half + half / 2 + 8;
      case ($urandom_range(0, 7))
         0:       return $urandom;
         1:       return 32'(centre + half + longint'($urandom_range(0, 2)) - 1);
         2:       return 32'(centre - half + longint'($urandom_range(0, 2)) - 1);
         default: return 32'(centre + longint'($urandom) % (2 * span + 1) - span);
      endcase
   endfunction

   // Response side back-pressure in random bursts.
   initial begin : rsp_pressure
      forever begin
         @(posedge clock);
         if (!reset && $urandom_range(0, 99) < idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: the slowest legal run is well under a tenth of this.
   initial begin : watchdog
      #5_000_000;
      $display("timeout: %0d responses checked, %0d still open", checked_count, open_answers);
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] qx;
      logic [31:0] qy;
      logic [31:0] scale;
      longint      room;
      longint      d;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_pct = 15;

      // reset values: zero-size box at the origin, default push-out scale
      send_point(32'd0, 32'd0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'hFFFF_FFFF, 32'd1);
      drain_points();

      // 20 x 10 box at the origin: every region, edges, inside and ties
      program_box(32'd0, 32'd0, 20 * UNIT, 10 * UNIT, 32'd282);
      send_point( 15 * UNIT,  -8 * UNIT);
      send_point(  0,         -8 * UNIT);
      send_point(-15 * UNIT,  -8 * UNIT);
      send_point(-15 * UNIT,   0);
      send_point(-15 * UNIT,   8 * UNIT);
      send_point(  0,          8 * UNIT);
      send_point( 15 * UNIT,   8 * UNIT);
      send_point( 15 * UNIT,   0);
      // on the corner lines and faces: not inside, compares go the closed way
      send_point( 10 * UNIT,  -5 * UNIT);
      send_point(-10 * UNIT,   5 * UNIT);
      send_point( 10 * UNIT,   0);
      send_point(-10 * UNIT,   0);
      // inside, inside with equal face distances, dead centre
      send_point(  3 * UNIT,   1 * UNIT);
      send_point( -3 * UNIT,  -1 * UNIT);
      send_point(  7 * UNIT,   2 * UNIT);
      send_point(  0,          0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000);
      drain_points();

      // largest box at the far corner with the largest scale: saturation
      program_box(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_point(32'd0, 32'd0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'd0);
      drain_points();

      // odd raw extents, zero scale
      program_box(32'd0, 32'd0, 32'd7, 32'd5, 32'd0);
      send_point(32'd2, 32'd1);
      send_point(32'd3, 32'd2);
      send_point(-32'sd3, -32'sd2);
      drain_points();

      // random boxes; the last one runs without any idling
      for (int phase = 0; phase < 12; phase++) begin
         case ($urandom_range(0, 4))
            0:       scale = 32'd0;
            1:       scale = 32'd1023;
            2:       scale = 32'd256;
            default: scale = $urandom_range(0, 1023);
         endcase
         // junk above the scale field must not matter
         scale = scale | ($urandom & 32'hFFFF_FC00);
         program_box(pick_coord(), pick_coord(), pick_extent(), pick_extent(), scale);
         if (phase == 11) begin
            idle_pct = 0;
         end else begin
            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 45);
         end
         repeat (160) begin
            if ($urandom_range(0, 9) == 0) begin
               // equal distance to an x face and a y face
               room = (half_w < half_h) ? half_w : half_h;
               d = $urandom_range(0, 32'(room));
               qx = 32'(set_cx + ($urandom_range(0, 1) ? half_w - d : d - half_w));
               qy = 32'(set_cy + ($urandom_range(0, 1) ? half_h - d : d - half_h));
            end else begin
               qx = near_coord(set_cx, half_w);
               qy = near_coord(set_cy, half_h);
            end
            send_point(qx, qy);
         end
         drain_points();
      end

      // let any stray response beat show up before the verdict
      repeat (20) @(posedge clock);
      $display("checked %0d points over %0d box settings, %0d of them strictly inside",
               checked_count, settings_used, inside_hits);
      $display("field mismatches and stray beats: %0d", fail_count);
      if (fail_count == 0 && open_answers == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/rpq_pkg.sv
rtl/core/rpq_cfg.sv
rtl/core/rpq_eval.sv
rtl/core/rectangle_point_region_query.sv
sim/region_query_checker.sv
sim/rectangle_point_region_query_tb.sv
